// ===== rtl/core/clle_pkg.sv =====
// ============================================================================
// clle_pkg: shared constants for the cursor linked list engine
// Field widths of the command and result items, command and status codes.
// ============================================================================
`default_nettype none

package clle_pkg;

    // Item field widths
    localparam int POS_W       = 10;
    localparam int VALUE_W     = 32;
    localparam int STATUS_W    = 2;
    localparam int INDEX_OUT_W = 10;

    // Command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DELETE = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_POS  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_SPACE = 2'd2;

endpackage : clle_pkg

`default_nettype wire

// ===== rtl/core/clle_link_store.sv =====
// ============================================================================
// clle_link_store: link memory of the node store
// One write port, one registered read port, and the post-reset pass that
// loads the initial chains (free chain 0..NODE_COUNT-2, empty data list).
// ============================================================================
`default_nettype none

module clle_link_store #(
    parameter int NODE_COUNT = 1024
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [$clog2(NODE_COUNT)-1:0] rd_addr,
    output logic      [$clog2(NODE_COUNT)-1:0] rd_data,
    input  wire logic                          wr_en,
    input  wire logic [$clog2(NODE_COUNT)-1:0] wr_addr,
    input  wire logic [$clog2(NODE_COUNT)-1:0] wr_data,
    output logic                               busy
);
    import clle_pkg::*;

    localparam int IDX_W = $clog2(NODE_COUNT);
    localparam logic [IDX_W-1:0] LAST_NODE = IDX_W'(NODE_COUNT - 1);
    localparam logic [IDX_W-1:0] FREE_TAIL = IDX_W'(NODE_COUNT - 2);

    logic [IDX_W-1:0] mem [NODE_COUNT];

    logic             clr_active_reg;
    logic             clr_active_next;
    logic [IDX_W-1:0] clr_addr_reg;
    logic [IDX_W-1:0] clr_addr_next;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [IDX_W-1:0] mem_wdata;

    // Clearing pass: one entry per cycle after reset
    always_comb
    begin
        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        if (clr_active_reg)
        begin
            clr_addr_next = clr_addr_reg + IDX_W'(1);
            if (clr_addr_reg == LAST_NODE)
            begin
                clr_active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else
        begin
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
        end
    end

    // Write source: initial chain during the pass, else the sequencer
    always_comb
    begin
        if (clr_active_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = (clr_addr_reg >= FREE_TAIL) ? '0 : clr_addr_reg + IDX_W'(1);
        end
        else
        begin
            mem_we    = wr_en;
            mem_waddr = wr_addr;
            mem_wdata = wr_data;
        end
    end

    // Memory array with a registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data <= mem[rd_addr];
    end

    assign busy = clr_active_reg;

endmodule : clle_link_store

`default_nettype wire

// ===== rtl/core/cursor_linked_list_engine_core.sv =====
// An insert pops a free node, walks to the predecessor and links it in; a
// delete walks there too, unlinks the victim and frees it. An insert with no
// free node stops after the free head read; a bad position skips the memories.
// One item at a time; the next item is taken the cycle after its result is
// registered. After reset a clearing pass loads the link memory, during which
// no item is accepted. Data memory is not initialized.
// ============================================================================
// cursor_linked_list_engine_core: cursor linked list with a free list
// Node 0 heads the free chain, node NODE_COUNT-1 heads the data list. A
// sequencer walks the link memory one link per cycle and relinks nodes.
// ============================================================================
`default_nettype none

module cursor_linked_list_engine_core #(
    parameter int NODE_COUNT = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic                               cmd,
    input  wire logic        [clle_pkg::POS_W-1:0]  position,
    input  wire logic signed [clle_pkg::VALUE_W-1:0] value,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic        [clle_pkg::STATUS_W-1:0]    status,
    output logic        [clle_pkg::INDEX_OUT_W-1:0] node_index,
    output logic signed [clle_pkg::VALUE_W-1:0]     removed_value
);
    import clle_pkg::*;

    localparam int IDX_W = $clog2(NODE_COUNT);
    localparam int CMP_W = ((POS_W > IDX_W) ? POS_W : IDX_W) + 1;
    localparam logic [IDX_W-1:0] FREE_HEAD = '0;
    localparam logic [IDX_W-1:0] LIST_HEAD = IDX_W'(NODE_COUNT - 1);

    // Sequencer states
    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_FREE_RD   = 4'd1;
    localparam logic [3:0] ST_FRESH_RD  = 4'd2;
    localparam logic [3:0] ST_WALK      = 4'd3;
    localparam logic [3:0] ST_INS_LINK  = 4'd4;
    localparam logic [3:0] ST_VICTIM    = 4'd5;
    localparam logic [3:0] ST_PUSH      = 4'd6;
    localparam logic [3:0] ST_PUSH_HEAD = 4'd7;
    localparam logic [3:0] ST_DONE      = 4'd8;

    function automatic logic [IDX_W-1:0] clamp_node(input logic [IDX_W-1:0] n);
        return ({1'b0, n} < (IDX_W+1)'(NODE_COUNT)) ? n : '0;
    endfunction

    // Control registers
    logic [3:0]       state_reg,     state_next;
    logic             out_valid_reg, out_valid_next;
    logic [IDX_W-1:0] len_reg,       len_next;

    // Working registers
    logic                  cmd_reg,         cmd_next;
    logic [DATA_WIDTH-1:0] value_reg,       value_next;
    logic [IDX_W-1:0]      fresh_reg,       fresh_next;
    logic [IDX_W-1:0]      node_reg,        node_next;
    logic [IDX_W-1:0]      victim_reg,      victim_next;
    logic [POS_W-1:0]      remaining_reg,   remaining_next;
    logic [STATUS_W-1:0]   res_status_reg,  res_status_next;
    logic [IDX_W-1:0]      res_index_reg,   res_index_next;
    logic [VALUE_W-1:0]    res_removed_reg, res_removed_next;

    // Output registers
    logic [STATUS_W-1:0]    out_status_reg,  out_status_next;
    logic [INDEX_OUT_W-1:0] out_index_reg,   out_index_next;
    logic [VALUE_W-1:0]     out_removed_reg, out_removed_next;

    // Memory ports
    logic [IDX_W-1:0]      link_raddr;
    logic [IDX_W-1:0]      link_rdata;
    logic                  link_we;
    logic [IDX_W-1:0]      link_waddr;
    logic [IDX_W-1:0]      link_wdata;
    logic                  link_busy;
    logic [IDX_W-1:0]      link_next_node;

    logic [DATA_WIDTH-1:0] data_mem [NODE_COUNT];
    logic                  data_we;
    logic [IDX_W-1:0]      data_waddr;
    logic [IDX_W-1:0]      data_raddr;
    logic [DATA_WIDTH-1:0] data_rdata;

    // Range checks against the kept list length
    logic [CMP_W-1:0] pos_cmp;
    logic [CMP_W-1:0] len_cmp;
    logic             ins_ok;
    logic             del_ok;

    assign pos_cmp        = CMP_W'(position);
    assign len_cmp        = CMP_W'(len_reg);
    assign ins_ok         = (position != '0) && (pos_cmp <= len_cmp + CMP_W'(1));
    assign del_ok         = (position != '0) && (pos_cmp <= len_cmp);
    assign link_next_node = clamp_node(link_rdata);

    assign in_ready = (state_reg == ST_IDLE) && !link_busy;

    clle_link_store #(
        .NODE_COUNT (NODE_COUNT)
    ) u_link_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (link_raddr),
        .rd_data (link_rdata),
        .wr_en   (link_we),
        .wr_addr (link_waddr),
        .wr_data (link_wdata),
        .busy    (link_busy)
    );

    // Data memory with a registered read port
    always_ff @(posedge clk)
    begin
        if (data_we)
        begin
            data_mem[data_waddr] <= value_reg;
        end
        data_rdata <= data_mem[data_raddr];
    end

    // Sequencer: read-modify-write of the link memory. Accesses are ordered
    // so that no entry is read for use in the same cycle as it is written.
    always_comb
    begin
        state_next       = state_reg;
        out_valid_next   = out_valid_reg;
        len_next         = len_reg;
        cmd_next         = cmd_reg;
        value_next       = value_reg;
        fresh_next       = fresh_reg;
        node_next        = node_reg;
        victim_next      = victim_reg;
        remaining_next   = remaining_reg;
        res_status_next  = res_status_reg;
        res_index_next   = res_index_reg;
        res_removed_next = res_removed_reg;
        out_status_next  = out_status_reg;
        out_index_next   = out_index_reg;
        out_removed_next = out_removed_reg;
        link_raddr       = node_reg;
        link_we          = 1'b0;
        link_waddr       = '0;
        link_wdata       = '0;
        data_we          = 1'b0;
        data_waddr       = fresh_reg;
        data_raddr       = victim_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd_next         = cmd;
                    value_next       = DATA_WIDTH'(value);
                    remaining_next   = position - POS_W'(1);
                    res_status_next  = STATUS_OK;
                    res_index_next   = '0;
                    res_removed_next = '0;
                    if (cmd == CMD_INSERT)
                    begin
                        if (!ins_ok)
                        begin
                            res_status_next = STATUS_BAD_POS;
                            state_next      = ST_DONE;
                        end
                        else
                        begin
                            link_raddr = FREE_HEAD;
                            state_next = ST_FREE_RD;
                        end
                    end
                    else
                    begin
                        if (!del_ok)
                        begin
                            res_status_next = STATUS_BAD_POS;
                            state_next      = ST_DONE;
                        end
                        else
                        begin
                            link_raddr = LIST_HEAD;
                            node_next  = LIST_HEAD;
                            state_next = ST_WALK;
                        end
                    end
                end
            end

            // Head of the free chain is the node to allocate
            ST_FREE_RD:
            begin
                if (link_next_node == '0)
                begin
                    res_status_next = STATUS_NO_SPACE;
                    state_next      = ST_DONE;
                end
                else
                begin
                    fresh_next = link_next_node;
                    link_raddr = link_next_node;
                    state_next = ST_FRESH_RD;
                end
            end

            // Pop the fresh node, store its data, start the walk
            ST_FRESH_RD:
            begin
                link_we    = 1'b1;
                link_waddr = FREE_HEAD;
                link_wdata = link_next_node;
                data_we    = 1'b1;
                link_raddr = LIST_HEAD;
                node_next  = LIST_HEAD;
                state_next = ST_WALK;
            end

            // One link per cycle; at the end link_rdata holds the
            // predecessor's successor
            ST_WALK:
            begin
                if (remaining_reg != '0)
                begin
                    node_next      = link_next_node;
                    link_raddr     = link_next_node;
                    remaining_next = remaining_reg - POS_W'(1);
                end
                else if (cmd_reg == CMD_INSERT)
                begin
                    link_we    = 1'b1;
                    link_waddr = fresh_reg;
                    link_wdata = link_rdata;
                    state_next = ST_INS_LINK;
                end
                else
                begin
                    victim_next = link_next_node;
                    link_raddr  = link_next_node;
                    data_raddr  = link_next_node;
                    state_next  = ST_VICTIM;
                end
            end

            ST_INS_LINK:
            begin
                link_we         = 1'b1;
                link_waddr      = node_reg;
                link_wdata      = fresh_reg;
                len_next        = len_reg + IDX_W'(1);
                res_index_next  = fresh_reg;
                state_next      = ST_DONE;
            end

            // Unlink the victim, fetch free head
            ST_VICTIM:
            begin
                link_we          = 1'b1;
                link_waddr       = node_reg;
                link_wdata       = link_rdata;
                link_raddr       = FREE_HEAD;
                res_removed_next = VALUE_W'(data_rdata);
                state_next       = ST_PUSH;
            end

            ST_PUSH:
            begin
                link_we    = 1'b1;
                link_waddr = victim_reg;
                link_wdata = link_rdata;
                state_next = ST_PUSH_HEAD;
            end

            ST_PUSH_HEAD:
            begin
                link_we        = 1'b1;
                link_waddr     = FREE_HEAD;
                link_wdata     = victim_reg;
                len_next       = len_reg - IDX_W'(1);
                res_index_next = victim_reg;
                state_next     = ST_DONE;
            end

            // Hand the result to the output register once it is free
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next   = 1'b1;
                    out_status_next  = res_status_reg;
                    out_index_next   = INDEX_OUT_W'(res_index_reg);
                    out_removed_next = res_removed_reg;
                    state_next       = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            len_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            len_reg       <= len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        value_reg       <= value_next;
        fresh_reg       <= fresh_next;
        node_reg        <= node_next;
        victim_reg      <= victim_next;
        remaining_reg   <= remaining_next;
        res_status_reg  <= res_status_next;
        res_index_reg   <= res_index_next;
        res_removed_reg <= res_removed_next;
        out_status_reg  <= out_status_next;
        out_index_reg   <= out_index_next;
        out_removed_reg <= out_removed_next;
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign node_index    = out_index_reg;
    assign removed_value = $signed(out_removed_reg);

    // Assertions
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= IDX_W'(NODE_COUNT - 2))
        else $error("list length beyond node capacity");

    a_success_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && res_status_reg == STATUS_OK) |-> (res_index_reg != '0))
        else $error("successful operation reports node zero");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && res_status_reg != STATUS_OK)
            |-> (res_index_reg == '0 && res_removed_reg == '0))
        else $error("failed operation reports nonzero fields");

    a_len_change: assert property (@(posedge clk) disable iff (!rst_n)
        (len_reg != $past(len_reg))
            |-> ($past(state_reg) == ST_INS_LINK || $past(state_reg) == ST_PUSH_HEAD))
        else $error("list length changed outside a relink step");

endmodule : cursor_linked_list_engine_core

`default_nettype wire

// ===== tb/sv/cursor_linked_list_engine_core_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// cursor_linked_list_engine_core_tb: self-checking bench for the list engine
// Queues insert and delete commands (edge cases, then random traffic that
// grows the list to a few hundred nodes with some long tail walks). Every
// accepted item is run through a local copy of the link store to predict its
// result. Sender and receiver idle at random. A watchdog ends a stuck run.
// ============================================================================

module cursor_linked_list_engine_core_tb;

    import clle_pkg::*;

    localparam int NODE_COUNT     = 1024;
    localparam int MAX_DATA_NODES = NODE_COUNT - 2;
    localparam int FREE_HEAD      = 0;
    localparam int LIST_HEAD      = NODE_COUNT - 1;
    localparam int MAX_POS        = (1 << POS_W) - 1;
    localparam int HOLD_AT        = 30;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 1100;
    localparam int WATCHDOG_LIMIT = 8000;

    typedef struct packed {
        logic                      cmd;
        logic [POS_W-1:0]          pos;
        logic signed [VALUE_W-1:0] value;
        logic                      drain;
    } list_op_t;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic [INDEX_OUT_W-1:0]    node_index;
        logic signed [VALUE_W-1:0] removed;
    } list_result_t;

    logic                             clk           = 1'b0;
    logic                             rst_n         = 1'b0;
    logic                             in_valid      = 1'b0;
    logic                             in_ready;
    logic                             cmd           = CMD_INSERT;
    logic        [POS_W-1:0]          position      = '0;
    logic signed [VALUE_W-1:0]        value         = '0;
    logic                             out_valid;
    logic                             out_ready     = 1'b0;
    logic        [STATUS_W-1:0]       status;
    logic        [INDEX_OUT_W-1:0]    node_index;
    logic signed [VALUE_W-1:0]        removed_value;

    // Pending commands and predicted results
    list_op_t     op_q[$];
    list_result_t result_q[$];
    list_op_t     cur_op;

    // Local copy of the node store
    logic [INDEX_OUT_W-1:0] link_mem [NODE_COUNT];
    logic [VALUE_W-1:0]     data_mem [NODE_COUNT];
    int unsigned            list_len;

    int unsigned sent_count;
    int unsigned done_count;
    int unsigned gap_left;
    int unsigned stall_left;
    int unsigned hold_left;
    int unsigned quiet_cycles;
    int unsigned mismatch_count;
    int unsigned gen_len;

    cursor_linked_list_engine_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .cmd           (cmd),
        .position      (position),
        .value         (value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .node_index    (node_index),
        .removed_value (removed_value)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // List prediction
    // ------------------------------------------------------------------
    task automatic clear_list_model();
        for (int n = 0; n < NODE_COUNT; n++)
            link_mem[n] = INDEX_OUT_W'(n + 1);
        link_mem[MAX_DATA_NODES] = '0;   // free chain stops short of the list head
        link_mem[LIST_HEAD]      = '0;   // empty data list
        list_len = 0;
    endtask

    function automatic logic [INDEX_OUT_W-1:0] node_before(int unsigned p);
        logic [INDEX_OUT_W-1:0] node;
        node = INDEX_OUT_W'(LIST_HEAD);
        for (int unsigned j = 1; j < p; j++)
            node = link_mem[node];
        return node;
    endfunction

    function automatic list_result_t apply_list_op(list_op_t op);
        list_result_t           r;
        logic [INDEX_OUT_W-1:0] fresh;
        logic [INDEX_OUT_W-1:0] pred;
        logic [INDEX_OUT_W-1:0] victim;
        int unsigned            p;
        r = '0;
        p = op.pos;
        if (op.cmd == CMD_INSERT) begin
            if (p < 1 || p > list_len + 1) begin
                r.status = STATUS_BAD_POS;
            end else if (link_mem[FREE_HEAD] == '0) begin
                r.status = STATUS_NO_SPACE;
            end else begin
                fresh               = link_mem[FREE_HEAD];
                link_mem[FREE_HEAD] = link_mem[fresh];
                pred                = node_before(p);
                data_mem[fresh]     = op.value;
                link_mem[fresh]     = link_mem[pred];
                link_mem[pred]      = fresh;
                list_len++;
                r.status     = STATUS_OK;
                r.node_index = fresh;
            end
        end else begin
            if (p < 1 || p > list_len) begin
                r.status = STATUS_BAD_POS;
            end else begin
                pred                = node_before(p);
                victim              = link_mem[pred];
                r.removed           = data_mem[victim];
                link_mem[pred]      = link_mem[victim];
                link_mem[victim]    = link_mem[FREE_HEAD];
                link_mem[FREE_HEAD] = victim;
                list_len--;
                r.status     = STATUS_OK;
                r.node_index = victim;
            end
        end
        return r;
    endfunction

    // Idle draw per item; every fourth stretch of 40 items runs without gaps
    function automatic int unsigned idle_draw(int unsigned k);
        return ((k / 40) % 4 == 3) ? 0 : $urandom_range(0, 18);
    endfunction

    // ------------------------------------------------------------------
    // Command generation (tracks the list length the commands will produce)
    // ------------------------------------------------------------------
    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic push_op(logic c, int unsigned p, logic [VALUE_W-1:0] v, bit drain);
        list_op_t op;
        op.cmd   = c;
        op.pos   = POS_W'(p);
        op.value = v;
        op.drain = drain;
        op_q.push_back(op);
        if (c == CMD_INSERT) begin
            if (p >= 1 && p <= gen_len + 1 && gen_len < MAX_DATA_NODES)
                gen_len++;
        end else if (p >= 1 && p <= gen_len) begin
            gen_len--;
        end
    endtask

    // Mostly well-formed commands near the front of the list, some out of range
    task automatic push_random(int unsigned ins_pct, int unsigned span, int unsigned bad_pct);
        logic        c;
        int unsigned p;
        int unsigned hi;
        c = ($urandom_range(0, 99) < ins_pct) ? CMD_INSERT : CMD_DELETE;
        if ($urandom_range(0, 99) < bad_pct) begin
            hi = (c == CMD_INSERT) ? gen_len + 2 : gen_len + 1;
            p  = ($urandom_range(0, 2) == 0 || hi > MAX_POS) ? 0 : $urandom_range(hi, MAX_POS);
        end else begin
            if (gen_len == 0)
                c = CMD_INSERT;
            hi = (c == CMD_INSERT) ? gen_len + 1 : gen_len;
            if (hi > span)
                hi = span;
            p = $urandom_range(1, hi);
        end
        push_op(c, p, pick_value(), $urandom_range(0, 59) == 0);
    endtask

    // ------------------------------------------------------------------
    // Driver: offers queued items, predicts each one on acceptance
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin : drive_items
        logic fire;
        if (!rst_n) begin
            in_valid   <= 1'b0;
            cmd        <= CMD_INSERT;
            position   <= '0;
            value      <= '0;
            sent_count = 0;
            gap_left   = 0;
            clear_list_model();
        end else begin
            fire = in_valid && in_ready;
            if (fire) begin
                result_q.push_back(apply_list_op(cur_op));
                sent_count++;
                gap_left = idle_draw(sent_count);
            end
            if (!in_valid || fire) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (op_q.size() != 0
                             && !(op_q[0].drain && sent_count != done_count)) begin
                    cur_op   = op_q.pop_front();
                    cmd      <= cur_op.cmd;
                    position <= cur_op.pos;
                    value    <= cur_op.value;
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks results, stalls the output at random
    // ------------------------------------------------------------------
    task automatic compare_field(string name, logic [31:0] want_v, logic [31:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin : check_results
        list_result_t want;
        if (!rst_n) begin
            out_ready      <= 1'b0;
            done_count     <= 0;
            stall_left     = 0;
            hold_left      = 0;
            mismatch_count = 0;
        end else begin
            if (out_valid && out_ready) begin
                if (result_q.size() == 0) begin
                    $display("%0t: result with nothing expected, status %0d node %0d",
                             $time, status, node_index);
                    mismatch_count++;
                end else begin
                    want = result_q.pop_front();
                    compare_field("status", 32'(want.status), 32'(status));
                    compare_field("node_index", 32'(want.node_index), 32'(node_index));
                    compare_field("removed_value", want.removed, removed_value);
                end
                done_count <= done_count + 1;
                stall_left = idle_draw(done_count + 1);
                // long hold-off so the engine backs up onto its input
                if (done_count == HOLD_AT)
                    hold_left = HOLD_CYCLES;
            end else if (hold_left > 0) begin
                hold_left--;
            end else if (stall_left > 0) begin
                stall_left--;
            end
            out_ready <= (stall_left == 0 && hold_left == 0);
        end
    end

    // Watchdog: no handshake on either side for too long
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        int unsigned ins_pct;
        gen_len      = 0;
        quiet_cycles = 0;

        // Edge cases: empty list, value extremes, head/middle/tail, free node reuse
        push_op(CMD_DELETE, 1, $urandom, 1'b0);
        push_op(CMD_INSERT, 0, 32'h1234_5678, 1'b0);
        push_op(CMD_INSERT, 2, 32'h1234_5678, 1'b0);
        push_op(CMD_INSERT, 1, 32'h7FFF_FFFF, 1'b0);
        push_op(CMD_INSERT, 1, 32'h8000_0000, 1'b0);
        push_op(CMD_INSERT, 3, 32'h0000_0000, 1'b0);
        push_op(CMD_INSERT, 2, 32'hFFFF_FFFF, 1'b0);
        push_op(CMD_INSERT, MAX_POS, 32'hDEAD_BEEF, 1'b0);
        push_op(CMD_INSERT, 6, 32'hDEAD_BEEF, 1'b0);
        push_op(CMD_DELETE, 0, $urandom, 1'b0);
        push_op(CMD_DELETE, 5, $urandom, 1'b0);
        push_op(CMD_DELETE, MAX_POS, $urandom, 1'b0);
        push_op(CMD_DELETE, 4, $urandom, 1'b0);
        push_op(CMD_DELETE, 2, $urandom, 1'b0);
        push_op(CMD_INSERT, 2, 32'h5555_5555, 1'b0);
        push_op(CMD_INSERT, 1, 32'hAAAA_AAAA, 1'b0);
        push_op(CMD_DELETE, 1, $urandom, 1'b1);
        push_op(CMD_DELETE, 3, $urandom, 1'b0);
        push_op(CMD_DELETE, 1, $urandom, 1'b0);
        push_op(CMD_DELETE, 1, $urandom, 1'b0);
        push_op(CMD_INSERT, 1, 32'h0000_0001, 1'b1);

        // Mixed traffic on a short list
        repeat (260) begin
            ins_pct = (gen_len < 8) ? 75 : (gen_len > 40) ? 30 : 55;
            push_random(ins_pct, 64, 10);
        end

        // Grow the list; now and then append at the tail for a long walk
        repeat (230) begin
            if ($urandom_range(0, 19) == 0)
                push_op(CMD_INSERT, gen_len + 1, pick_value(), 1'b0);
            else
                push_random(90, 24, 3);
        end

        // Long list: positions just past either end, tail delete and append
        push_op(CMD_INSERT, gen_len + 2, pick_value(), 1'b0);
        push_op(CMD_DELETE, gen_len + 1, $urandom, 1'b0);
        push_op(CMD_DELETE, gen_len, $urandom, 1'b0);
        push_op(CMD_INSERT, gen_len + 1, pick_value(), 1'b0);
        push_op(CMD_INSERT, MAX_POS, pick_value(), 1'b0);
        push_op(CMD_INSERT, 0, pick_value(), 1'b0);
        push_op(CMD_DELETE, MAX_POS, $urandom, 1'b0);
        push_op(CMD_DELETE, 1, $urandom, 1'b1);
        push_op(CMD_INSERT, 1, pick_value(), 1'b0);

        // Back to mixed traffic near the head of a long list
        repeat (60)
            push_random(40, 64, 10);

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (op_q.size() != 0 || in_valid || sent_count != done_count)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (mismatch_count == 0 && result_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches, %0d results never arrived",
                     mismatch_count, result_q.size());
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/clle_pkg.sv
rtl/core/clle_link_store.sv
rtl/core/cursor_linked_list_engine_core.sv
tb/sv/cursor_linked_list_engine_core_tb.sv
